// File: src/csrl_pkg.sv
package csrl_pkg;

  // work mode codes of an input transaction
  localparam logic [1:0] MODE_OTHER  = 2'd0;
  localparam logic [1:0] MODE_CHG    = 2'd1;
  localparam logic [1:0] MODE_DIS    = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    KIND_VSET = 3'd0,
    KIND_ISET = 3'd1,
    KIND_ON   = 3'd2,
    KIND_OFF  = 3'd3,
    KIND_DIS  = 3'd4,
    KIND_CHG  = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    REG_MAX_V  = 3'd0,
    REG_MIN_V  = 3'd1,
    REG_MAX_I  = 3'd2,
    REG_MIN_I  = 3'd3,
    REG_I_CAP  = 3'd4,
    REG_MAX_P  = 3'd5,
    REG_V_RAT  = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHARE,   // ceiling share division
    ST_SCALE_M, // meas * ratio (serial multiply)
    ST_SCALE_D, // / 1000
    ST_PLIM,    // power / scaled voltage
    ST_DISQ,    // power / (meas*100)
    ST_FINISH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic        enable;
    logic [15:0] need_voltage;
    logic [15:0] need_current;
    logic [1:0]  work_mode;
    logic [6:0]  valid_modules;
    logic [15:0] measured_voltage;
    logic        module_dir_high;
    logic        car_limit;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  command_kind;
    logic [22:0] command_value;
    logic        last;
  } out_item_t;

endpackage

// File: src/charger_setpoint_ramp_limiter.sv
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_ready   | in_item_t
// out     | out | out_valid/out_ready | out_item_t (3 or 4 per transaction)
// cfg     | in  | cfg_we              | cfg_index, cfg_wdata
// an off tick, or an on tick in mode other or unused, goes from idle straight to
// the finish state before its commands come out; a charge tick runs three 32-step
// restoring divisions and a 16-step shift-add multiply on one datapath (with no
// valid modules, the share division is skipped); a discharge tick runs one division.
// each command leaves only while out_ready is high; the next transaction is
// taken once the last command of the tick has left. reset is synchronous.
module charger_setpoint_ramp_limiter
  import csrl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_wdata
);

  localparam logic [22:0] RampStep = 23'd500;
  localparam logic [22:0] DisCap   = 23'd16000;

  logic [15:0] max_v_r, min_v_r, max_i_r, min_i_r, i_cap_r, v_rat_r;
  logic [11:0] max_p_r;
  logic [22:0] vset_r, vset_nxt, iset_r, iset_nxt;

  state_t      st_r, st_nxt;
  in_item_t    it_r;
  logic [15:0] nc_r;         // capped need_current

  // shared bit-serial divider / multiplier datapath
  logic [31:0] q_r, q_nxt;     // dividend shifts out, quotient shifts in
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] t_r, t_nxt;     // share candidate
  logic [31:0] sv_r, sv_nxt;   // scaled voltage / product

  logic [2:0]  ocnt_r, ocnt_nxt;
  logic [2:0]  onum_r, onum_nxt;
  kind_t       k2_r, k2_nxt, k3_r, k3_nxt;

  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        dstep_done;
  logic [31:0] pw;
  logic [22:0] mxi, mni;
  logic [31:0] t_cl, lim_t, cand, ramp;
  logic        chg, dis;

  assign chg = it_r.work_mode == MODE_CHG;
  assign dis = it_r.work_mode == MODE_DIS;
  assign pw  = 32'(max_p_r) * 32'd1000000;
  assign mxi = 23'(max_i_r) * 23'd100;
  assign mni = 23'(min_i_r) * 23'd100;

  // one restoring step
  assign rem_sh     = {rem_r[31:0], q_r[31]};
  assign rem_sub    = rem_sh - {1'b0, dvs_r};
  assign dstep_done = cnt_r == 6'd31;

  function automatic logic [31:0] clamp_i(input logic [31:0] v,
                                          input logic [22:0] hi,
                                          input logic [22:0] lo);
    if (v > 32'(hi)) return 32'(hi);
    if (v < 32'(lo)) return 32'(lo);
    return v;
  endfunction

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_v_r <= 16'd5000; min_v_r <= 16'd2000;
      max_i_r <= 16'd100;  min_i_r <= 16'd5;
      i_cap_r <= 16'd2000; max_p_r <= 12'd30; v_rat_r <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_V: max_v_r <= cfg_wdata;
        REG_MIN_V: min_v_r <= cfg_wdata;
        REG_MAX_I: max_i_r <= cfg_wdata;
        REG_MIN_I: min_i_r <= cfg_wdata;
        REG_I_CAP: i_cap_r <= cfg_wdata;
        REG_MAX_P: max_p_r <= cfg_wdata[11:0];
        REG_V_RAT: v_rat_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_valid) begin
        if (!in_data.enable || !(in_data.work_mode inside {MODE_CHG, MODE_DIS}))
          st_nxt = ST_FINISH;
        else if (in_data.work_mode == MODE_DIS)
          st_nxt = ST_DISQ;
        else if (in_data.valid_modules != 7'd0)
          st_nxt = ST_SHARE;
        else
          st_nxt = ST_SCALE_M;
      end
      ST_SHARE:   if (dstep_done) st_nxt = ST_SCALE_M;
      ST_SCALE_M: if (cnt_r == 6'd15) st_nxt = ST_SCALE_D;
      ST_SCALE_D: if (dstep_done) st_nxt = ST_PLIM;
      ST_PLIM:    if (dstep_done) st_nxt = ST_FINISH;
      ST_DISQ:    if (dstep_done) st_nxt = ST_FINISH;
      ST_FINISH:  st_nxt = ST_EMIT;
      ST_EMIT:    if (out_ready && ocnt_r == onum_r - 3'd1) st_nxt = ST_IDLE;
      default:    st_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    logic [15:0] nc_in;
    logic [31:0] v16;
    logic [31:0] q32;
    logic [31:0] c;
    q_nxt = q_r; rem_nxt = rem_r; dvs_nxt = dvs_r; cnt_nxt = cnt_r;
    t_nxt = t_r; sv_nxt = sv_r; vset_nxt = vset_r; iset_nxt = iset_r;
    ocnt_nxt = ocnt_r; onum_nxt = onum_r; k2_nxt = k2_r; k3_nxt = k3_r;
    nc_in = (in_data.need_current > i_cap_r) ? i_cap_r : in_data.need_current;
    v16 = '0; q32 = '0; c = '0;
    t_cl = '0; lim_t = '0; cand = '0; ramp = '0;
    if (st_r inside {ST_SHARE, ST_SCALE_D, ST_PLIM, ST_DISQ}) begin
      cnt_nxt = cnt_r + 6'd1;
      if (!rem_sub[32]) begin
        rem_nxt = rem_sub; q_nxt = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;  q_nxt = {q_r[30:0], 1'b0};
      end
    end
    case (st_r)
      ST_IDLE: if (in_valid) begin
        cnt_nxt = '0; rem_nxt = '0;
        ocnt_nxt = '0;
        if (in_data.enable && in_data.work_mode == MODE_DIS) begin
          q_nxt   = pw;
          dvs_nxt = 32'(in_data.measured_voltage) * 32'd100;
        end else begin
          q_nxt   = 32'(nc_in) * 32'd100 + 32'(in_data.valid_modules) - 32'd1;
          dvs_nxt = 32'(in_data.valid_modules);
        end
        t_nxt = 32'(iset_r);
        sv_nxt = '0;
      end
      ST_SHARE: if (dstep_done) begin
        t_nxt = q_nxt; cnt_nxt = '0;
      end
      ST_SCALE_M: begin
        // shift-add: ratio bit by bit, msb first
        cnt_nxt = cnt_r + 6'd1;
        sv_nxt = (sv_r << 1) +
                 (v_rat_r[4'(15 - cnt_r[3:0])] ? 32'(it_r.measured_voltage) : 32'd0);
        if (cnt_r == 6'd15) begin
          cnt_nxt = '0; rem_nxt = '0;
          q_nxt = sv_nxt; dvs_nxt = 32'd1000;
        end
      end
      ST_SCALE_D: if (dstep_done) begin
        v16 = {16'd0, q_nxt[15:0]};
        if (v16 == 32'd0) v16 = 32'd1;
        cnt_nxt = '0; rem_nxt = '0; q_nxt = pw; dvs_nxt = v16;
      end
      ST_PLIM: if (dstep_done) begin
        t_cl  = clamp_i(t_r, mxi, mni);
        lim_t = (t_cl > q_nxt) ? q_nxt : t_cl;
        if (lim_t <= 32'(iset_r)) cand = lim_t;
        else begin
          ramp = 32'(iset_r) + 32'(RampStep);
          cand = (ramp >= lim_t) ? lim_t : ramp;
        end
        iset_nxt = 23'(clamp_i(cand, mxi, mni));
        if (it_r.need_voltage > max_v_r) vset_nxt = 23'(32'(max_v_r) * 32'd100);
        else if (it_r.need_voltage > min_v_r) vset_nxt = 23'(32'(it_r.need_voltage) * 32'd100);
        else vset_nxt = 23'(32'(min_v_r) * 32'd100);
      end
      ST_DISQ: if (dstep_done) begin
        q32 = (dvs_r == 32'd0) ? 32'hFFFF_FFFF : q_nxt;
        // q*100 capped: anything above DisCap saturates anyway
        c = (q32 > 32'd160) ? 32'd16001 : q32 * 32'd100;
        if (it_r.car_limit && c >= 32'(nc_r) * 32'd100) c = 32'(nc_r) * 32'd100;
        if (c > 32'(DisCap)) c = 32'(DisCap);
        iset_nxt = 23'(c);
        vset_nxt = 23'(dvs_r);
      end
      ST_FINISH: begin
        if (it_r.enable) begin
          onum_nxt = 3'd3;
          k2_nxt = ((it_r.module_dir_high && dis) || (!it_r.module_dir_high && chg)) ?
                   KIND_ON : (dis ? KIND_DIS : KIND_CHG);
        end else begin
          k2_nxt = KIND_OFF;
          k3_nxt = dis ? KIND_DIS : KIND_CHG;
          onum_nxt = ((!it_r.module_dir_high && dis) || (it_r.module_dir_high && chg)) ?
                     3'd4 : 3'd3;
        end
      end
      ST_EMIT: if (out_ready) ocnt_nxt = ocnt_r + 3'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; vset_r <= '0; iset_r <= '0; ocnt_r <= '0; onum_r <= '0;
    end else begin
      st_r <= st_nxt; vset_r <= vset_nxt; iset_r <= iset_nxt;
      ocnt_r <= ocnt_nxt; onum_r <= onum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt; rem_r <= rem_nxt; dvs_r <= dvs_nxt; cnt_r <= cnt_nxt;
    t_r <= t_nxt; sv_r <= sv_nxt; k2_r <= k2_nxt; k3_r <= k3_nxt;
    if (st_r == ST_IDLE && in_valid) begin
      it_r <= in_data;
      nc_r <= (in_data.need_current > i_cap_r) ? i_cap_r : in_data.need_current;
    end
  end

  // outputs
  always_comb begin
    in_ready  = st_r == ST_IDLE;
    out_valid = st_r == ST_EMIT;
    out_data  = '0;
    out_data.last = ocnt_r == onum_r - 3'd1;
    case (ocnt_r)
      3'd0: begin
        out_data.command_kind  = KIND_VSET;
        out_data.command_value = it_r.enable ? vset_r : '0;
      end
      3'd1: begin
        out_data.command_kind  = KIND_ISET;
        out_data.command_value = it_r.enable ? iset_r : '0;
      end
      3'd2: out_data.command_kind = k2_r;
      default: out_data.command_kind = k3_r;
    endcase
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while emitting");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last |=> in_ready)
    else $error("tick did not end after last");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ocnt_r < onum_r) else $error("command count overrun");
`endif

endmodule

// File: tb/setpoint_checker.sv
module setpoint_checker
  import csrl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  input  logic      cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int        errors,
  output int        pending,
  output int        commands_seen
);

  // shadow configuration and setpoint state
  logic [63:0] max_v, min_v, max_i, min_i, i_cap, max_p, v_rat;
  logic [63:0] v_set, i_set;
  out_item_t   cmd_q[$];

  function automatic logic [63:0] clamp_current(logic [63:0] v);
    if (v > max_i * 100) return max_i * 100;
    if (v < min_i * 100) return min_i * 100;
    return v;
  endfunction

  task automatic push_cmd(kind_t k, logic [63:0] v);
    out_item_t c;
    c.command_kind  = k;
    c.command_value = v[22:0];
    c.last          = 1'b0;
    cmd_q.push_back(c);
  endtask

  // compute the commands of one tick and queue them
  task automatic predict_tick(in_item_t it);
    logic [63:0] nc, share, sv, lim, q, c;
    logic chg, dis;
    out_item_t tail;
    nc  = 64'(it.need_current);
    chg = it.work_mode == MODE_CHG;
    dis = it.work_mode == MODE_DIS;
    if (nc > i_cap) nc = i_cap;
    if (it.enable) begin
      if (chg) begin
        if (it.need_voltage > max_v) v_set = max_v * 100;
        else if (it.need_voltage > min_v) v_set = 64'(it.need_voltage) * 100;
        else v_set = min_v * 100;
        if (it.valid_modules != 0)
          share = (nc * 100 + 64'(it.valid_modules) - 1) / 64'(it.valid_modules);
        else
          share = i_set;
        share = clamp_current(share);
        sv = ((64'(it.measured_voltage) * v_rat) / 1000) & 64'hFFFF;
        if (sv == 0) sv = 1;
        lim = (max_p * 1000000) / sv;
        if (share > lim) share = lim;
        if (share <= i_set) i_set = share;
        else begin
          i_set = i_set + 500;
          if (i_set >= share) i_set = share;
        end
        i_set = clamp_current(i_set);
      end
      if (dis) begin
        v_set = 64'(it.measured_voltage) * 100;
        if (v_set == 0) q = 64'hFFFFFFFF;
        else q = (max_p * 1000000) / v_set;
        c = q * 100;
        if (it.car_limit && c >= nc * 100) c = nc * 100;
        if (c > 16000) c = 16000;
        i_set = c;
      end
      v_set &= 64'h7FFFFF;
      i_set &= 64'h7FFFFF;
      push_cmd(KIND_VSET, v_set);
      push_cmd(KIND_ISET, i_set);
      if ((it.module_dir_high && dis) || (!it.module_dir_high && chg))
        push_cmd(KIND_ON, 0);
      else
        push_cmd(dis ? KIND_DIS : KIND_CHG, 0);
    end else begin
      push_cmd(KIND_VSET, 0);
      push_cmd(KIND_ISET, 0);
      push_cmd(KIND_OFF, 0);
      if (!it.module_dir_high && dis) push_cmd(KIND_DIS, 0);
      if (it.module_dir_high && chg) push_cmd(KIND_CHG, 0);
    end
    tail = cmd_q.pop_back();
    tail.last = 1'b1;
    cmd_q.push_back(tail);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      max_v <= 5000; min_v <= 2000; max_i <= 100; min_i <= 5;
      i_cap <= 2000; max_p <= 30; v_rat <= 1000;
      v_set = 0; i_set = 0;
      errors <= 0;
      commands_seen <= 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_MAX_V: max_v <= 64'(cfg_wdata);
          REG_MIN_V: min_v <= 64'(cfg_wdata);
          REG_MAX_I: max_i <= 64'(cfg_wdata);
          REG_MIN_I: min_i <= 64'(cfg_wdata);
          REG_I_CAP: i_cap <= 64'(cfg_wdata);
          REG_MAX_P: max_p <= 64'(cfg_wdata[11:0]);
          REG_V_RAT: v_rat <= 64'(cfg_wdata);
          default: ;
        endcase
      end
      // result transaction compare
      if (out_valid && out_ready) begin
        commands_seen <= commands_seen + 1;
        if (cmd_q.size() == 0) begin
          $display("%0t: unexpected command %p", $time, out_data);
          errors <= errors + 1;
        end else begin
          out_item_t exp_cmd;
          exp_cmd = cmd_q.pop_front();
          if (exp_cmd.command_kind !== out_data.command_kind ||
              exp_cmd.command_value !== out_data.command_value ||
              exp_cmd.last !== out_data.last) begin
            $display("%0t: mismatch expected kind=%0d value=%0d last=%0d,",
                     $time, exp_cmd.command_kind, exp_cmd.command_value, exp_cmd.last,
                     " actual kind=%0d value=%0d last=%0d",
                     out_data.command_kind, out_data.command_value, out_data.last);
            errors <= errors + 1;
          end
        end
      end
      // input transaction predict (blocking state update inside task)
      if (in_valid && in_ready) predict_tick(in_data);
    end
    pending = cmd_q.size();
  end

endmodule

// File: tb/tb_charger_setpoint_ramp_limiter.sv
module tb_charger_setpoint_ramp_limiter;
  import csrl_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  int          errors, pending, commands_seen;
  int          send_idle = 0, recv_stall = 0;
  int          ticks_sent = 0;
  int          quiet_cycles = 0;

  always #1 clk = ~clk;

  charger_setpoint_ramp_limiter i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  setpoint_checker i_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_wdata,
    .errors, .pending, .commands_seen
  );

  // random receiver stall
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall);

  // watchdog on accepted transactions
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // one register write, then one cycle with the enable low
  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // drop valid and wait until every expected command has come
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (130) @(posedge clk);
  endtask

  task automatic send_tick(in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
  endtask

  function automatic in_item_t random_tick();
    in_item_t it;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.enable = ($urandom_range(9) != 0);
    it.work_mode = ($urandom_range(9) < 8) ? 2'($urandom_range(1, 2)) :
                   2'($urandom_range(3));
    it.valid_modules = ($urandom_range(7) == 0) ? 7'($urandom_range(127)) :
                       7'($urandom_range(64));
    case ($urandom_range(3))
      0: it.measured_voltage = 16'($urandom_range(30));
      1: it.measured_voltage = 16'($urandom_range(2000, 8000));
      default: ;
    endcase
    if ($urandom_range(1)) it.need_current = 16'($urandom_range(3000));
    return it;
  endfunction

  task automatic random_config(bit extreme);
    write_reg(REG_MAX_V, extreme ? 16'hFFFF : 16'($urandom_range(3000, 9000)));
    write_reg(REG_MIN_V, extreme ? 16'h0000 : 16'($urandom_range(500, 4000)));
    write_reg(REG_MAX_I, extreme ? 16'hFFFF : 16'($urandom));
    write_reg(REG_MIN_I, extreme ? 16'h0000 : 16'($urandom_range(200)));
    write_reg(REG_I_CAP, extreme ? 16'hFFFF : 16'($urandom));
    write_reg(REG_MAX_P, extreme ? 16'd4000 : 16'($urandom_range(4000)));
    write_reg(REG_V_RAT, extreme ? 16'hFFFF : 16'($urandom));
  endtask

  in_item_t t;
  int phase;

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed ticks at reset configuration
    t = '0; t.enable = 1'b1; t.work_mode = MODE_CHG; t.need_voltage = 16'hFFFF;
    t.need_current = 16'hFFFF; t.valid_modules = 7'd64; t.measured_voltage = 16'd4000;
    send_tick(t);
    t.need_voltage = 16'd3000; t.valid_modules = 7'd0; send_tick(t);
    t.need_voltage = 16'd0; t.valid_modules = 7'd127; t.measured_voltage = 16'd0;
    send_tick(t);
    t.measured_voltage = 16'hFFFF; t.module_dir_high = 1'b1; send_tick(t);
    t.work_mode = MODE_DIS; t.measured_voltage = 16'd0; send_tick(t);
    t.car_limit = 1'b1; t.need_current = 16'd10; send_tick(t);
    t.measured_voltage = 16'hFFFF; t.module_dir_high = 1'b0; send_tick(t);
    t.work_mode = MODE_OTHER; send_tick(t);
    t.work_mode = MODE_UNUSED; t.module_dir_high = 1'b1; send_tick(t);
    for (int m = 0; m < 4; m++) begin
      t = '0; t.work_mode = 2'(m); send_tick(t);
      t.module_dir_high = 1'b1; send_tick(t);
    end
    drain();

    // crossed limits and extreme registers
    write_reg(REG_MIN_V, 16'd6000); write_reg(REG_MAX_V, 16'd1000);
    write_reg(REG_MIN_I, 16'd900); write_reg(REG_MAX_I, 16'd50);
    write_reg(REG_MAX_P, 16'd4000); write_reg(REG_V_RAT, 16'd0);
    write_reg(REG_I_CAP, 16'd0);
    t = '0; t.enable = 1'b1; t.work_mode = MODE_CHG; t.need_voltage = 16'd3000;
    t.valid_modules = 7'd3; send_tick(t);
    t.need_voltage = 16'd7000; send_tick(t);
    drain();

    // random phases with different idling
    for (phase = 0; phase < 5; phase++) begin
      random_config(phase == 1);
      case (phase)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 52; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 52; end
        3: begin send_idle = 19; recv_stall = 19; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      for (int k = 0; k < 18; k++) begin
        send_tick(random_tick());
        if (k == 10) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
      drain();
    end
    recv_stall = 0;
    repeat (20) @(posedge clk);

    $display("covered %0d ticks and %0d commands over reset, crossed,",
             ticks_sent, commands_seen, " extreme and random settings");
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
